[sv/ppc_pkg.sv]
`timescale 1ns / 1ps
// Package for the premultiplied pixel compositor.
// Holds the operator codes and the operator type; depends on nothing.
package ppc_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_SOURCE = 2'd1;
   localparam op_type OP_OVER   = 2'd2;
   localparam op_type OP_IN_REV = 2'd3;

   localparam int NUM_CH = 4;

endpackage

[sv/premultiplied_pixel_compositor_top.sv]
`timescale 1ns / 1ps
// Premultiplied ARGB Porter-Duff compositor, five-stage pipeline.
// Depends on ppc_pkg for the operator codes.

// The block takes one pixel request per clock while req_ready is high. A
// request passes through two normalized multiplies, each a
// multiply stage followed by a stage that divides by the full-scale value,
// and then a last stage that applies the operator and drives the
// result port from its own register. Every stage holds
// its own valid bit and advances whenever the stage after it is empty or
// moving, so bubbles close up and a stalled result does not block requests
// while the pipeline still has room. No state survives between requests.
module premultiplied_pixel_compositor_top #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ppc_pkg::op_type         req_op,
   input  logic [CHANNEL_BITS-1:0] req_src_alpha,
   input  logic [CHANNEL_BITS-1:0] req_src_red,
   input  logic [CHANNEL_BITS-1:0] req_src_green,
   input  logic [CHANNEL_BITS-1:0] req_src_blue,
   input  logic [CHANNEL_BITS-1:0] req_mask_alpha,
   input  logic [CHANNEL_BITS-1:0] req_dst_alpha,
   input  logic [CHANNEL_BITS-1:0] req_dst_red,
   input  logic [CHANNEL_BITS-1:0] req_dst_green,
   input  logic [CHANNEL_BITS-1:0] req_dst_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CHANNEL_BITS-1:0] rsp_out_alpha,
   output logic [CHANNEL_BITS-1:0] rsp_out_red,
   output logic [CHANNEL_BITS-1:0] rsp_out_green,
   output logic [CHANNEL_BITS-1:0] rsp_out_blue
);
   import ppc_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int PW = 2 * CB;
   localparam logic [CB-1:0] FULL = '1;
   // (M - 1) / 2 with M = 2^CB - 1; adding it before the divide gives
   // round-to-nearest with halves up, since M is odd.
   localparam logic [PW-1:0] RND = {{(CB + 1){1'b0}}, {(CB - 1){1'b1}}};
   localparam logic [CB:0] FULL_X1 = {1'b0, FULL};
   localparam logic [CB:0] FULL_X2 = {FULL, 1'b0};

   // Divide by 2^CB - 1 for a product below 2^(2*CB): estimate from the high
   // half, then correct with the remainder, which stays below twice M plus one.
   function automatic logic [CB-1:0] div_full(input logic [PW-1:0] t);
      logic [CB:0] q0;
      logic [CB:0] r0;
      logic [CB:0] q;
      q0 = {1'b0, t[PW-1:CB]};
      r0 = {1'b0, t[CB-1:0]} + q0;
      q  = q0 + {{CB{1'b0}}, (r0 >= FULL_X1)} + {{CB{1'b0}}, (r0 >= FULL_X2)};
      return q[CB-1:0];
   endfunction

   // Channel order in every array: alpha, red, green, blue.
   logic [CB-1:0] req_src [NUM_CH];
   logic [CB-1:0] req_dst [NUM_CH];

   logic adv1, adv2, adv3, adv4, adv5;

   logic          v1_ff, v1_in;
   op_type        op1_ff;
   logic [PW-1:0] t1_ff  [NUM_CH];
   logic [PW-1:0] t1_in  [NUM_CH];
   logic [CB-1:0] d1_ff  [NUM_CH];

   logic          v2_ff, v2_in;
   op_type        op2_ff;
   logic [CB-1:0] s2_ff  [NUM_CH];
   logic [CB-1:0] s2_in  [NUM_CH];
   logic [CB-1:0] d2_ff  [NUM_CH];

   logic          v3_ff, v3_in;
   op_type        op3_ff;
   logic [CB-1:0] s3_ff  [NUM_CH];
   logic [PW-1:0] t3_ff  [NUM_CH];
   logic [PW-1:0] t3_in  [NUM_CH];
   logic [CB-1:0] y3;

   logic          v4_ff, v4_in;
   op_type        op4_ff;
   logic [CB-1:0] s4_ff  [NUM_CH];
   logic [CB-1:0] q4_ff  [NUM_CH];
   logic [CB-1:0] q4_in  [NUM_CH];

   logic          v5_ff, v5_in;
   logic [CB-1:0] r5_ff  [NUM_CH];
   logic [CB-1:0] r5_in  [NUM_CH];
   logic [CB:0]   sum5   [NUM_CH];

   assign req_src[0] = req_src_alpha;
   assign req_src[1] = req_src_red;
   assign req_src[2] = req_src_green;
   assign req_src[3] = req_src_blue;
   assign req_dst[0] = req_dst_alpha;
   assign req_dst[1] = req_dst_red;
   assign req_dst[2] = req_dst_green;
   assign req_dst[3] = req_dst_blue;

   // A stage may load when it is empty or its content moves on.
   assign adv5 = !v5_ff || rsp_ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   assign v1_in = req_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;
   assign v5_in = v4_ff;

   // Over scales the destination by the inverse source alpha, in_reverse by
   // the source alpha itself.
   assign y3 = (op2_ff == OP_OVER) ? (FULL - s2_ff[0]) : s2_ff[0];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         t1_in[c] = PW'(req_src[c] * req_mask_alpha) + RND;
         s2_in[c] = div_full(t1_ff[c]);
         t3_in[c] = PW'(d2_ff[c] * y3) + RND;
         q4_in[c] = div_full(t3_ff[c]);
         sum5[c]  = {1'b0, s4_ff[c]} + {1'b0, q4_ff[c]};
         case (op4_ff)
            OP_CLEAR:  r5_in[c] = '0;
            OP_SOURCE: r5_in[c] = s4_ff[c];
            OP_OVER:   r5_in[c] = sum5[c][CB] ? FULL : sum5[c][CB-1:0];
            OP_IN_REV: r5_in[c] = q4_ff[c];
            default:   r5_in[c] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= v1_in;
         if (adv2) v2_ff <= v2_in;
         if (adv3) v3_ff <= v3_in;
         if (adv4) v4_ff <= v4_in;
         if (adv5) v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         op1_ff <= req_op;
         t1_ff  <= t1_in;
         d1_ff  <= req_dst;
      end
      if (adv2) begin
         op2_ff <= op1_ff;
         s2_ff  <= s2_in;
         d2_ff  <= d1_ff;
      end
      if (adv3) begin
         op3_ff <= op2_ff;
         s3_ff  <= s2_ff;
         t3_ff  <= t3_in;
      end
      if (adv4) begin
         op4_ff <= op3_ff;
         s4_ff  <= s3_ff;
         q4_ff  <= q4_in;
      end
      if (adv5) begin
         r5_ff  <= r5_in;
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_out_alpha = r5_ff[0];
   assign rsp_out_red   = r5_ff[1];
   assign rsp_out_green = r5_ff[2];
   assign rsp_out_blue  = r5_ff[3];

   // A full pipeline facing a stalled output must refuse new requests.
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted into a full, stalled pipeline");

   // An empty first stage always has room.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("empty pipeline refused a request");

   // A held middle stage keeps its request and its operator code.
   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !adv4) |=> (v3_ff && $stable(op3_ff)))
      else $error("stalled stage three lost its request");

   // Clear produces an all-zero pixel.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && adv5 && op4_ff == OP_CLEAR) |=>
      (rsp_out_alpha == '0 && rsp_out_red == '0 &&
       rsp_out_green == '0 && rsp_out_blue == '0))
      else $error("clear request produced a nonzero pixel");

endmodule

[test/tb_premultiplied_pixel_compositor_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for premultiplied_pixel_compositor_top: random and
// directed pixel requests against a built-in Porter-Duff blend predictor.
// Depends on ppc_pkg and the compositor RTL.
module tb_premultiplied_pixel_compositor_top;
   import ppc_pkg::*;

   localparam int CB            = 8;
   localparam int FULL          = (1 << CB) - 1;
   localparam int RANDOM_REQS   = 1430;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 2000;

   typedef logic [0:3][CB-1:0] argb_type;   // alpha, red, green, blue

   typedef struct packed {
      op_type        op;
      argb_type      src;
      logic [CB-1:0] mask;
      argb_type      dst;
   } pixel_req_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   op_type        req_op = OP_CLEAR;
   logic [CB-1:0] req_src_alpha = '0;
   logic [CB-1:0] req_src_red = '0;
   logic [CB-1:0] req_src_green = '0;
   logic [CB-1:0] req_src_blue = '0;
   logic [CB-1:0] req_mask_alpha = '0;
   logic [CB-1:0] req_dst_alpha = '0;
   logic [CB-1:0] req_dst_red = '0;
   logic [CB-1:0] req_dst_green = '0;
   logic [CB-1:0] req_dst_blue = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CB-1:0] rsp_out_alpha;
   logic [CB-1:0] rsp_out_red;
   logic [CB-1:0] rsp_out_green;
   logic [CB-1:0] rsp_out_blue;

   pixel_req_type pixel_backlog[$];
   argb_type      blend_due[$];
   int            total_reqs = 0;
   int            req_count = 0;
   int            mismatch_count = 0;
   int            stall_cycles = 0;

   // Idle percentages per phase: sender light / receiver heavy, then swapped,
   // then no idling at all.
   int         send_idle_pct[3] = '{12, 49, 0};
   int         rsp_idle_pct[3]  = '{49, 12, 0};
   string      chan_name[4] = '{"out_alpha", "out_red", "out_green", "out_blue"};

   premultiplied_pixel_compositor_top #(.CHANNEL_BITS(CB)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_src_alpha (req_src_alpha),
      .req_src_red   (req_src_red),
      .req_src_green (req_src_green),
      .req_src_blue  (req_src_blue),
      .req_mask_alpha(req_mask_alpha),
      .req_dst_alpha (req_dst_alpha),
      .req_dst_red   (req_dst_red),
      .req_dst_green (req_dst_green),
      .req_dst_blue  (req_dst_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Normalized product x*y/FULL, rounded to nearest with halves going up.
   function automatic int norm_mul(int x, int y);
      return (2 * x * y + FULL) / (2 * FULL);
   endfunction

   function automatic argb_type blend_pixel(pixel_req_type r);
      argb_type s;
      argb_type o;
      int       inv;
      int       sum;
      for (int i = 0; i < 4; i++)
         s[i] = CB'(norm_mul(r.src[i], r.mask));
      inv = FULL - s[0];
      for (int i = 0; i < 4; i++) begin
         case (r.op)
            OP_CLEAR:  o[i] = '0;
            OP_SOURCE: o[i] = s[i];
            OP_OVER: begin
               sum = s[i] + norm_mul(r.dst[i], inv);
               o[i] = (sum > FULL) ? CB'(FULL) : CB'(sum);
            end
            default:   o[i] = CB'(norm_mul(r.dst[i], s[0]));
         endcase
      end
      return o;
   endfunction

   function automatic int idle_phase();
      int p;
      p = (total_reqs == 0) ? 0 : (req_count * 3) / total_reqs;
      return (p > 2) ? 2 : p;
   endfunction

   // Channels lean toward the two extremes so that saturation and the
   // zero-coverage paths come up often.
   function automatic logic [CB-1:0] rand_chan();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return CB'(FULL);
      return CB'($urandom_range(FULL));
   endfunction

   function automatic pixel_req_type make_req(op_type op, argb_type src, int mask,
                                              argb_type dst);
      pixel_req_type r;
      r.op   = op;
      r.src  = src;
      r.mask = CB'(mask);
      r.dst  = dst;
      return r;
   endfunction

   function automatic argb_type rand_pixel(bit premultiplied);
      argb_type p;
      p[0] = rand_chan();
      for (int i = 1; i < 4; i++)
         p[i] = premultiplied ? CB'($urandom_range(p[0])) : rand_chan();
      return p;
   endfunction

   // Request driver: a new request goes out only once the previous one has
   // been taken, so valid and payload hold steady while waiting.
   always @(posedge clock) begin : req_driver
      pixel_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_backlog.size() > 0 &&
             $urandom_range(99) >= send_idle_pct[idle_phase()]) begin
            nxt = pixel_backlog.pop_front();
            req_op         <= nxt.op;
            req_src_alpha  <= nxt.src[0];
            req_src_red    <= nxt.src[1];
            req_src_green  <= nxt.src[2];
            req_src_blue   <= nxt.src[3];
            req_mask_alpha <= nxt.mask;
            req_dst_alpha  <= nxt.dst[0];
            req_dst_red    <= nxt.dst[1];
            req_dst_green  <= nxt.dst[2];
            req_dst_blue   <= nxt.dst[3];
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts each accepted request and checks each accepted result.
   always @(posedge clock) begin : rsp_monitor
      pixel_req_type taken;
      argb_type      want;
      argb_type      got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct[idle_phase()]);
         if (req_valid && req_ready) begin
            taken = make_req(req_op,
                             {req_src_alpha, req_src_red, req_src_green, req_src_blue},
                             req_mask_alpha,
                             {req_dst_alpha, req_dst_red, req_dst_green, req_dst_blue});
            blend_due.push_back(blend_pixel(taken));
            req_count <= req_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue};
            if (blend_due.size() == 0) begin
               $error("result with no request outstanding: %h", got);
               mismatch_count++;
            end else begin
               want = blend_due.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got[i] !== want[i]) begin
                     $error("%s: expected %0d, actual %0d", chan_name[i], want[i], got[i]);
                     mismatch_count++;
                  end
               end
            end
         end
      end
   end

   // Watchdog: a long run of cycles with work outstanding and no handshake
   // on either side means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (req_valid || blend_due.size() > 0) begin
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[premultiplied_pixel_compositor_top] ERROR");
            $finish;
         end
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      argb_type opaque_white;
      argb_type zero_px;
      argb_type half_px;
      argb_type dst_px;
      int       pick;
      opaque_white = {CB'(FULL), CB'(FULL), CB'(FULL), CB'(FULL)};
      zero_px      = '0;
      half_px      = {8'd128, 8'd128, 8'd64, 8'd1};
      dst_px       = {8'd200, 8'd150, 8'd100, 8'd50};

      // Directed requests: field extremes, each operator, rounding at the
      // half point, color above alpha, and saturation of over.
      pixel_backlog.push_back(make_req(OP_CLEAR,  opaque_white, FULL, opaque_white));
      pixel_backlog.push_back(make_req(OP_CLEAR,  zero_px, 0, zero_px));
      pixel_backlog.push_back(make_req(OP_SOURCE, opaque_white, FULL, zero_px));
      pixel_backlog.push_back(make_req(OP_SOURCE, opaque_white, 0, opaque_white));
      pixel_backlog.push_back(make_req(OP_SOURCE, half_px, 128, dst_px));
      pixel_backlog.push_back(make_req(OP_SOURCE, {8'd1, 8'd1, 8'd1, 8'd1}, 128, zero_px));
      pixel_backlog.push_back(make_req(OP_SOURCE, zero_px, FULL, opaque_white));
      pixel_backlog.push_back(make_req(OP_OVER,   opaque_white, FULL, dst_px));
      pixel_backlog.push_back(make_req(OP_OVER,   zero_px, FULL, dst_px));
      pixel_backlog.push_back(make_req(OP_OVER,   half_px, FULL, opaque_white));
      pixel_backlog.push_back(make_req(OP_OVER,   {8'd0, 8'd255, 8'd255, 8'd255}, FULL,
                                       opaque_white));
      pixel_backlog.push_back(make_req(OP_OVER,   opaque_white, 0, dst_px));
      pixel_backlog.push_back(make_req(OP_OVER,   half_px, 128, dst_px));
      pixel_backlog.push_back(make_req(OP_OVER,   zero_px, 0, zero_px));
      pixel_backlog.push_back(make_req(OP_IN_REV, opaque_white, FULL, opaque_white));
      pixel_backlog.push_back(make_req(OP_IN_REV, zero_px, FULL, opaque_white));
      pixel_backlog.push_back(make_req(OP_IN_REV, half_px, FULL, dst_px));
      pixel_backlog.push_back(make_req(OP_IN_REV, opaque_white, 0, dst_px));
      pixel_backlog.push_back(make_req(OP_IN_REV, {8'd0, 8'd255, 8'd255, 8'd255}, 77,
                                       dst_px));

      // Random requests: mostly valid premultiplied pixels, the rest with
      // color channels free to exceed alpha.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(3);
         pixel_backlog.push_back(make_req(op_type'($urandom_range(3)),
                                          rand_pixel(pick != 0),
                                          rand_chan(),
                                          rand_pixel(pick != 1)));
      end
      total_reqs = pixel_backlog.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pixel_backlog.size() > 0 || req_valid)
         @(posedge clock);
      while (blend_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("[premultiplied_pixel_compositor_top] OK");
      else
         $display("[premultiplied_pixel_compositor_top] ERROR");
      $finish;
   end

endmodule
